// ----- rtl/core/tank_level_pump_alarm_controller_unit_assert.svh -----
// Assertion macros used by the checker file.
`ifndef TANK_LEVEL_PUMP_ALARM_CONTROLLER_UNIT_ASSERT_SVH
`define TANK_LEVEL_PUMP_ALARM_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define TLPAC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tlpac assertion failed");

// Next-cycle implication, off during reset.
`define TLPAC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tlpac assertion failed");

`endif

// ----- rtl/core/tlpac_pkg.sv -----
package tlpac_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TANK_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PERCENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PERCENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_BLINK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_BLINK = 3'd5;

    localparam logic [15:0] ECHO_TIMEOUT_US = 16'd30000;
    localparam logic [23:0] SOUND_MUL = 24'd343;
    localparam logic [24:0] FULL_MUL = 25'd20000;
    localparam logic [31:0] PCT_MUL = 32'd100;

    localparam logic [1:0] ZONE_LOW  = 2'd0;
    localparam logic [1:0] ZONE_MID  = 2'd1;
    localparam logic [1:0] ZONE_HIGH = 2'd2;
    localparam logic [1:0] ZONE_ERR  = 2'd3;

    localparam int PIN_WHITE = 0;
    localparam int PIN_GREEN = 1;
    localparam int PIN_BLUE  = 2;
    localparam int PIN_PUMP  = 3;
    localparam int PIN_BUZZ  = 4;

    localparam int CLS_DEPTH = 4;
    localparam int CLS_PTR_W = 2;
    localparam int CLS_CNT_W = 3;

    typedef struct packed {
        logic [9:0]  tank_height_cm;
        logic [6:0]  low_percent;
        logic [6:0]  high_percent;
        logic [15:0] warn_ms;
        logic [15:0] fast_blink_ms;
        logic [15:0] slow_blink_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  zone;
        logic        button_level;
        logic [31:0] now_ms;
    } t_cls;

    typedef struct packed {
        logic [4:0] pins;
        logic [1:0] zone;
        logic       manual_mode;
    } t_res;

endpackage

// ----- rtl/core/tank_level_pump_alarm_controller_unit.sv -----
// Tank level monitor: one request per sensor pass, one result per request, in order.
// Sustained rate is one request per clock while full is low. A request passes the two
// classification stages, the four-entry queue and the state update, which writes its
// result into the result queue. The two-stage classification pipeline and the queue
// hold up to four requests; full rises when all four places are taken, and the
// state update stalls only when its two-entry result queue is full and not popped.
module tank_level_pump_alarm_controller_unit import tlpac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [14:0]           i_echo_us,
    input  logic                  i_button_level,
    input  logic [31:0]           i_now_ms,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_top_light,
    output logic                  o_mid_light,
    output logic                  o_warn_light,
    output logic                  o_pump_on,
    output logic                  o_buzzer_on,
    output logic [1:0]            o_zone,
    output logic                  o_manual_mode
);

    t_cfg                 r_cfg;
    logic [CLS_CNT_W-1:0] r_credit;

    logic take;
    logic cls_valid;
    t_cls cls_wr;
    t_cls cls_rd;
    logic cls_empty;
    logic cls_read;
    t_res res;

    assign full = (r_credit == CLS_CNT_W'(CLS_DEPTH));
    assign take = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tank_height_cm <= 10'd100;
            r_cfg.low_percent    <= 7'd30;
            r_cfg.high_percent   <= 7'd80;
            r_cfg.warn_ms        <= 16'd5000;
            r_cfg.fast_blink_ms  <= 16'd250;
            r_cfg.slow_blink_ms  <= 16'd500;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TANK_HEIGHT:  r_cfg.tank_height_cm <= i_cfg_data[9:0];
                CFG_LOW_PERCENT:  r_cfg.low_percent    <= i_cfg_data[6:0];
                CFG_HIGH_PERCENT: r_cfg.high_percent   <= i_cfg_data[6:0];
                CFG_WARN_MS:      r_cfg.warn_ms        <= i_cfg_data;
                CFG_FAST_BLINK:   r_cfg.fast_blink_ms  <= i_cfg_data;
                CFG_SLOW_BLINK:   r_cfg.slow_blink_ms  <= i_cfg_data;
                default:          r_cfg                <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            case ({take, cls_read && !cls_empty})
                2'b10:   r_credit <= r_credit + 1'b1;
                2'b01:   r_credit <= r_credit - 1'b1;
                default: r_credit <= r_credit;
            endcase
        end
    end

    tlpac_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_take         (take),
        .i_echo_us      (i_echo_us),
        .i_button_level (i_button_level),
        .i_now_ms       (i_now_ms),
        .o_cls_valid    (cls_valid),
        .o_cls          (cls_wr)
    );

    tlpac_cls_fifo u_cls_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (cls_valid),
        .i_wr_data (cls_wr),
        .i_rd      (cls_read),
        .o_rd_data (cls_rd),
        .o_empty   (cls_empty)
    );

    tlpac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cls_empty (cls_empty),
        .i_cls       (cls_rd),
        .o_cls_rd    (cls_read),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_top_light   = res.pins[PIN_WHITE];
    assign o_mid_light   = res.pins[PIN_GREEN];
    assign o_warn_light  = res.pins[PIN_BLUE];
    assign o_pump_on     = res.pins[PIN_PUMP];
    assign o_buzzer_on   = res.pins[PIN_BUZZ];
    assign o_zone        = res.zone;
    assign o_manual_mode = res.manual_mode;

endmodule

// ----- rtl/core/tlpac_front.sv -----
module tlpac_front import tlpac_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_take,
    input  logic [14:0] i_echo_us,
    input  logic        i_button_level,
    input  logic [31:0] i_now_ms,
    output logic        o_cls_valid,
    output t_cls        o_cls
);

    logic        r_s1_v;
    logic        r_s1_err;
    logic [23:0] r_s1_dist;
    logic [24:0] r_s1_full;
    logic        r_s1_btn;
    logic [31:0] r_s1_now;

    logic        r_s2_v;
    logic        r_s2_err;
    logic [31:0] r_s2_scaled;
    logic [31:0] r_s2_low;
    logic [31:0] r_s2_high;
    logic        r_s2_btn;
    logic [31:0] r_s2_now;

    logic        n_s1_err;
    logic [23:0] n_s1_dist;
    logic [24:0] n_s1_full;
    logic [24:0] n_level;
    logic [31:0] n_s2_scaled;
    logic [31:0] n_s2_low;
    logic [31:0] n_s2_high;

    assign n_s1_err  = (i_echo_us == 15'd0) || ({1'b0, i_echo_us} > ECHO_TIMEOUT_US);
    assign n_s1_dist = 24'(i_echo_us) * SOUND_MUL;
    assign n_s1_full = 25'(i_cfg.tank_height_cm) * FULL_MUL;

    assign n_level     = ({1'b0, r_s1_dist} >= r_s1_full) ? 25'd0
                                                          : r_s1_full - {1'b0, r_s1_dist};
    assign n_s2_scaled = 32'(n_level) * PCT_MUL;
    assign n_s2_low    = 32'(i_cfg.low_percent) * 32'(r_s1_full);
    assign n_s2_high   = 32'(i_cfg.high_percent) * 32'(r_s1_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= i_take;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_err    <= n_s1_err;
        r_s1_dist   <= n_s1_dist;
        r_s1_full   <= n_s1_full;
        r_s1_btn    <= i_button_level;
        r_s1_now    <= i_now_ms;
        r_s2_err    <= r_s1_err;
        r_s2_scaled <= n_s2_scaled;
        r_s2_low    <= n_s2_low;
        r_s2_high   <= n_s2_high;
        r_s2_btn    <= r_s1_btn;
        r_s2_now    <= r_s1_now;
    end

    always_comb begin
        if (r_s2_err) begin
            o_cls.zone = ZONE_ERR;
        end else if (r_s2_scaled < r_s2_low) begin
            o_cls.zone = ZONE_LOW;
        end else if (r_s2_scaled < r_s2_high) begin
            o_cls.zone = ZONE_MID;
        end else begin
            o_cls.zone = ZONE_HIGH;
        end
        o_cls.button_level = r_s2_btn;
        o_cls.now_ms       = r_s2_now;
    end

    assign o_cls_valid = r_s2_v;

endmodule

// ----- rtl/core/tlpac_cls_fifo.sv -----
module tlpac_cls_fifo import tlpac_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cls i_wr_data,
    input  logic i_rd,
    output t_cls o_rd_data,
    output logic o_empty
);

    t_cls                 r_mem [CLS_DEPTH];
    logic [CLS_PTR_W-1:0] r_wr_ptr;
    logic [CLS_PTR_W-1:0] r_rd_ptr;
    logic [CLS_CNT_W-1:0] r_cnt;

    logic do_rd;

    assign o_empty   = (r_cnt == '0);
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_wr, do_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/core/tlpac_back.sv -----
module tlpac_back import tlpac_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cls_empty,
    input  t_cls i_cls,
    output logic o_cls_rd,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_res
);

    logic        r_last_button;
    logic        r_manual;
    logic        r_low_warn;
    logic [31:0] r_low_stamp;
    logic [31:0] r_blink_stamp;
    logic        r_blink_phase;
    logic [4:0]  r_pins;

    t_res        r_oq [2];
    logic        r_owp;
    logic        r_orp;
    logic [1:0]  r_ocnt;

    logic        n_last_button;
    logic        n_manual;
    logic        n_low_warn;
    logic [31:0] n_low_stamp;
    logic [31:0] n_blink_stamp;
    logic        n_blink_phase;
    logic [4:0]  n_pins;
    logic [31:0] warn_elapsed;
    logic [31:0] blink_elapsed;
    logic        blink_fast_due;
    logic        blink_slow_due;
    logic        take;
    logic        pop_ok;
    t_res        res;

    assign pop_ok   = i_pop && (r_ocnt != 2'd0);
    assign take     = !i_cls_empty && ((r_ocnt != 2'd2) || i_pop);
    assign o_cls_rd = take;
    assign o_empty  = (r_ocnt == 2'd0);
    assign o_res    = r_oq[r_orp];

    assign blink_elapsed  = i_cls.now_ms - r_blink_stamp;
    assign blink_fast_due = (blink_elapsed >= 32'(i_cfg.fast_blink_ms));
    assign blink_slow_due = (blink_elapsed >= 32'(i_cfg.slow_blink_ms));

    always_comb begin
        n_last_button = i_cls.button_level;
        n_manual      = r_manual ^ (r_last_button && !i_cls.button_level);
        n_low_warn    = r_low_warn;
        n_low_stamp   = r_low_stamp;
        n_blink_stamp = r_blink_stamp;
        n_blink_phase = r_blink_phase;
        n_pins        = r_pins;

        if (!r_low_warn && !n_manual) begin
            warn_elapsed = 32'd0;
        end else begin
            warn_elapsed = i_cls.now_ms - r_low_stamp;
        end

        if (i_cls.zone == ZONE_ERR) begin
            n_pins = '0;
        end else begin
            if (n_manual) begin
                n_pins[PIN_PUMP] = 1'b1;
            end
            case (i_cls.zone)
                ZONE_LOW: begin
                    if (!r_low_warn && !n_manual) begin
                        n_low_warn  = 1'b1;
                        n_low_stamp = i_cls.now_ms;
                    end
                    if (n_low_warn && (warn_elapsed < 32'(i_cfg.warn_ms)) && !n_manual) begin
                        n_pins[PIN_WHITE] = 1'b0;
                        n_pins[PIN_GREEN] = 1'b0;
                        if (blink_fast_due) begin
                            n_blink_stamp    = i_cls.now_ms;
                            n_blink_phase    = !r_blink_phase;
                            n_pins[PIN_BLUE] = !r_blink_phase;
                        end
                        n_pins[PIN_BUZZ] = 1'b1;
                        n_pins[PIN_PUMP] = 1'b0;
                    end else if (n_low_warn && (warn_elapsed >= 32'(i_cfg.warn_ms))) begin
                        n_pins[PIN_BLUE] = 1'b0;
                        n_pins[PIN_BUZZ] = 1'b0;
                        n_pins[PIN_PUMP] = 1'b1;
                    end
                end
                ZONE_MID: begin
                    n_low_warn        = 1'b0;
                    n_pins[PIN_WHITE] = 1'b0;
                    n_pins[PIN_BLUE]  = 1'b0;
                    n_pins[PIN_BUZZ]  = 1'b0;
                    if (blink_slow_due) begin
                        n_blink_stamp     = i_cls.now_ms;
                        n_blink_phase     = !r_blink_phase;
                        n_pins[PIN_GREEN] = !r_blink_phase;
                    end
                    if (!n_manual) begin
                        n_pins[PIN_PUMP] = 1'b0;
                    end
                end
                default: begin
                    n_low_warn        = 1'b0;
                    n_pins[PIN_GREEN] = 1'b0;
                    n_pins[PIN_BLUE]  = 1'b0;
                    n_pins[PIN_BUZZ]  = 1'b0;
                    if (blink_slow_due) begin
                        n_blink_stamp     = i_cls.now_ms;
                        n_blink_phase     = !r_blink_phase;
                        n_pins[PIN_WHITE] = !r_blink_phase;
                    end
                    if (!n_manual) begin
                        n_pins[PIN_PUMP] = 1'b0;
                    end
                end
            endcase
        end

        res.pins        = n_pins;
        res.zone        = i_cls.zone;
        res.manual_mode = n_manual;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_button <= 1'b1;
            r_manual      <= 1'b0;
            r_low_warn    <= 1'b0;
            r_low_stamp   <= '0;
            r_blink_stamp <= '0;
            r_blink_phase <= 1'b0;
            r_pins        <= '0;
        end else if (take) begin
            r_last_button <= n_last_button;
            r_manual      <= n_manual;
            r_low_warn    <= n_low_warn;
            r_low_stamp   <= n_low_stamp;
            r_blink_stamp <= n_blink_stamp;
            r_blink_phase <= n_blink_phase;
            r_pins        <= n_pins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_oq[r_owp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (take) begin
                r_owp <= !r_owp;
            end
            if (pop_ok) begin
                r_orp <= !r_orp;
            end
            case ({take, pop_ok})
                2'b10:   r_ocnt <= r_ocnt + 2'd1;
                2'b01:   r_ocnt <= r_ocnt - 2'd1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

endmodule

// ----- rtl/core/tlpac_checker.sv -----
`include "tank_level_pump_alarm_controller_unit_assert.svh"

module tlpac_checker import tlpac_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic       o_top_light,
    input logic       o_mid_light,
    input logic       o_warn_light,
    input logic       o_pump_on,
    input logic       o_buzzer_on,
    input logic [1:0] o_zone,
    input logic       o_manual_mode
);

    logic any_pin;
    logic mid_ok;

    assign any_pin = o_top_light || o_mid_light || o_warn_light || o_pump_on || o_buzzer_on;
    assign mid_ok  = !o_top_light && !o_warn_light && !o_buzzer_on
                     && (o_pump_on == o_manual_mode);

    `TLPAC_ASSERT_NOW(a_err_pins_low, !empty && (o_zone == ZONE_ERR), !any_pin)

    `TLPAC_ASSERT_NOW(a_mid_pins, !empty && (o_zone == ZONE_MID), mid_ok)

    `TLPAC_ASSERT_NOW(a_manual_pump, !empty && (o_zone != ZONE_ERR) && o_manual_mode, o_pump_on)

    `TLPAC_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(o_zone) && $stable(o_pump_on) && $stable(o_manual_mode))

endmodule

bind tank_level_pump_alarm_controller_unit tlpac_checker u_tlpac_checker (.*);

// ----- test/testbench.sv -----
module testbench;
    import tlpac_pkg::*;

    localparam logic [63:0] LEVEL_SCALE = 64'd20000;
    localparam logic [63:0] SOUND_STEP = 64'd343;
    localparam logic [63:0] PERCENT_SCALE = 64'd100;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = 8;
    localparam int CALM_TAIL = 120;
    localparam int PASSES_PER_PHASE = 150;

    typedef enum logic [1:0] {STEP_PASS, STEP_WRITE, STEP_SETTLE} step_kind_t;

    typedef struct {
        step_kind_t      kind;
        logic [14:0]     echo;
        logic            button;
        logic [31:0]     stamp;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } sensor_step_t;

    typedef struct {
        logic [4:0] pins;
        logic [1:0] zone;
        logic       manual;
    } panel_state_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [14:0] i_echo_us = '0;
    logic i_button_level = 1'b1;
    logic [31:0] i_now_ms = '0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic empty;
    logic pop = 1'b0;
    logic o_top_light;
    logic o_mid_light;
    logic o_warn_light;
    logic o_pump_on;
    logic o_buzzer_on;
    logic [1:0] o_zone;
    logic o_manual_mode;

    tank_level_pump_alarm_controller_unit i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #600000;
        $display("simulation failed");
        $finish;
    end

    // tank model state and settings
    logic [9:0]  tank_cm;
    logic [6:0]  low_pct;
    logic [6:0]  high_pct;
    logic [15:0] warn_len;
    logic [15:0] fast_period;
    logic [15:0] slow_period;
    logic        last_btn;
    logic        manual_on;
    logic        warn_active;
    logic [31:0] warn_start_ms;
    logic [31:0] blink_last_ms;
    logic        blink_level;
    logic [4:0]  pin_state;

    sensor_step_t sensor_passes[$];
    panel_state_t panel_expect[$];
    int n_accepted = 0;
    int results_seen = 0;
    int failures = 0;
    int settle_cnt = 0;
    int gap_left = 0;
    int pop_gap = 0;
    int idle_pct = 20;
    logic calm = 1'b0;
    logic hold_off = 1'b0;
    logic [9:0] plan_height = 10'd100;

    function automatic void reset_tank_model();
        tank_cm = 10'd100;
        low_pct = 7'd30;
        high_pct = 7'd80;
        warn_len = 16'd5000;
        fast_period = 16'd250;
        slow_period = 16'd500;
        last_btn = 1'b1;
        manual_on = 1'b0;
        warn_active = 1'b0;
        warn_start_ms = '0;
        blink_last_ms = '0;
        blink_level = 1'b0;
        pin_state = '0;
    endfunction

    function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_TANK_HEIGHT: tank_cm = data[9:0];
            CFG_LOW_PERCENT: low_pct = data[6:0];
            CFG_HIGH_PERCENT: high_pct = data[6:0];
            CFG_WARN_MS: warn_len = data;
            CFG_FAST_BLINK: fast_period = data;
            CFG_SLOW_BLINK: slow_period = data;
            default: ;
        endcase
    endfunction

    function automatic void toggle_blink(input logic [31:0] stamp, input logic [15:0] period,
                                         input int pin);
        logic [31:0] age;
        age = stamp - blink_last_ms;
        if (age >= {16'd0, period}) begin
            blink_last_ms = stamp;
            blink_level = !blink_level;
            pin_state[pin] = blink_level;
        end
    endfunction

    function automatic void run_monitor_pass(input logic [14:0] echo, input logic btn,
                                             input logic [31:0] stamp);
        logic [63:0] full_scale;
        logic [63:0] travel;
        logic [63:0] level;
        logic [63:0] scaled;
        logic [31:0] warn_age;
        logic [1:0]  zn;
        panel_state_t res;
        if (last_btn && !btn)
            manual_on = !manual_on;
        last_btn = btn;
        if (echo == 0 || {1'b0, echo} > ECHO_TIMEOUT_US) begin
            pin_state = '0;
            zn = ZONE_ERR;
        end else begin
            full_scale = 64'(tank_cm) * LEVEL_SCALE;
            travel = 64'(echo) * SOUND_STEP;
            level = (travel >= full_scale) ? 64'd0 : full_scale - travel;
            scaled = level * PERCENT_SCALE;
            if (manual_on)
                pin_state[PIN_PUMP] = 1'b1;
            if (scaled < 64'(low_pct) * full_scale) begin
                zn = ZONE_LOW;
                if (!warn_active && !manual_on) begin
                    warn_active = 1'b1;
                    warn_start_ms = stamp;
                end
                warn_age = stamp - warn_start_ms;
                if (warn_active && warn_age < {16'd0, warn_len} && !manual_on) begin
                    pin_state[PIN_WHITE] = 1'b0;
                    pin_state[PIN_GREEN] = 1'b0;
                    toggle_blink(stamp, fast_period, PIN_BLUE);
                    pin_state[PIN_BUZZ] = 1'b1;
                    pin_state[PIN_PUMP] = 1'b0;
                end else if (warn_active && warn_age >= {16'd0, warn_len}) begin
                    pin_state[PIN_BLUE] = 1'b0;
                    pin_state[PIN_BUZZ] = 1'b0;
                    pin_state[PIN_PUMP] = 1'b1;
                end
            end else if (scaled < 64'(high_pct) * full_scale) begin
                zn = ZONE_MID;
                warn_active = 1'b0;
                pin_state[PIN_WHITE] = 1'b0;
                pin_state[PIN_BLUE] = 1'b0;
                pin_state[PIN_BUZZ] = 1'b0;
                toggle_blink(stamp, slow_period, PIN_GREEN);
                if (!manual_on)
                    pin_state[PIN_PUMP] = 1'b0;
            end else begin
                zn = ZONE_HIGH;
                warn_active = 1'b0;
                pin_state[PIN_GREEN] = 1'b0;
                pin_state[PIN_BLUE] = 1'b0;
                pin_state[PIN_BUZZ] = 1'b0;
                toggle_blink(stamp, slow_period, PIN_WHITE);
                if (!manual_on)
                    pin_state[PIN_PUMP] = 1'b0;
            end
        end
        res.pins = pin_state;
        res.zone = zn;
        res.manual = manual_on;
        panel_expect.push_back(res);
    endfunction

    task automatic add_pass(input logic [14:0] echo, input logic btn, input logic [31:0] stamp);
        sensor_step_t s;
        s.kind = STEP_PASS;
        s.echo = echo;
        s.button = btn;
        s.stamp = stamp;
        s.idx = '0;
        s.data = '0;
        sensor_passes.push_back(s);
    endtask

    task automatic add_step(input step_kind_t kind, input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
        sensor_step_t s;
        s.kind = kind;
        s.echo = '0;
        s.button = 1'b1;
        s.stamp = '0;
        s.idx = idx;
        s.data = data;
        sensor_passes.push_back(s);
    endtask

    // upper data bits beyond each register's width carry noise
    task automatic write_settings(input logic [9:0] h, input logic [6:0] lo, input logic [6:0] hi,
                                  input logic [15:0] warn, input logic [15:0] fast,
                                  input logic [15:0] slow);
        add_step(STEP_WRITE, CFG_TANK_HEIGHT, {6'($urandom), h});
        add_step(STEP_WRITE, CFG_LOW_PERCENT, {9'($urandom), lo});
        add_step(STEP_WRITE, CFG_HIGH_PERCENT, {9'($urandom), hi});
        add_step(STEP_WRITE, CFG_WARN_MS, warn);
        add_step(STEP_WRITE, CFG_FAST_BLINK, fast);
        add_step(STEP_WRITE, CFG_SLOW_BLINK, slow);
        add_step(STEP_WRITE, CFG_SPARE_LO, 16'($urandom));
        add_step(STEP_WRITE, CFG_SPARE_HI, 16'($urandom));
        plan_height = h;
    endtask

    always @(posedge i_clk) begin
        if ($urandom_range(0, 47) == 0)
            idle_pct <= $urandom_range(0, 3) * 12;
    end

    // driver
    always @(posedge i_clk) begin
        sensor_step_t s;
        logic nxt_push;
        logic nxt_we;
        if (!i_rst_n) begin
            reset_tank_model();
            push <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            nxt_push = push;
            nxt_we = 1'b0;
            if (i_cfg_we)
                apply_setting(i_cfg_idx, i_cfg_data);
            if (push && !full) begin
                run_monitor_pass(i_echo_us, i_button_level, i_now_ms);
                n_accepted++;
                nxt_push = 1'b0;
            end
            if (n_accepted == results_seen && !push)
                settle_cnt++;
            else
                settle_cnt = 0;
            if (!(push && full)) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (sensor_passes.size() == 0) begin
                end else if (sensor_passes[0].kind != STEP_PASS) begin
                    if (settle_cnt >= SETTLE_CYCLES) begin
                        s = sensor_passes.pop_front();
                        if (s.kind == STEP_WRITE) begin
                            i_cfg_idx <= s.idx;
                            i_cfg_data <= s.data;
                            nxt_we = 1'b1;
                        end
                    end
                end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
                    gap_left = $urandom_range(0, 2);
                end else begin
                    s = sensor_passes.pop_front();
                    i_echo_us <= s.echo;
                    i_button_level <= s.button;
                    i_now_ms <= s.stamp;
                    nxt_push = 1'b1;
                end
            end
            push <= nxt_push;
            i_cfg_we <= nxt_we;
            calm <= (sensor_passes.size() < CALM_TAIL);
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        panel_state_t want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                results_seen <= results_seen + 1;
                if (panel_expect.size() == 0) begin
                    $error("result with none expected, zone %0d", o_zone);
                    failures++;
                end else begin
                    want = panel_expect.pop_front();
                    check_field("top_light", want.pins[PIN_WHITE], o_top_light);
                    check_field("mid_light", want.pins[PIN_GREEN], o_mid_light);
                    check_field("warn_light", want.pins[PIN_BLUE], o_warn_light);
                    check_field("pump_on", want.pins[PIN_PUMP], o_pump_on);
                    check_field("buzzer_on", want.pins[PIN_BUZZ], o_buzzer_on);
                    check_field("zone", want.zone, o_zone);
                    check_field("manual_mode", want.manual, o_manual_mode);
                end
            end
            if (hold_off) begin
                pop <= 1'b0;
            end else if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
                pop_gap = $urandom_range(0, 2);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // hold the result side long enough to back up the input side
    initial begin
        while (n_accepted < 500)
            @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (60) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        logic [31:0] clock_ms;
        logic        btn_lvl;
        logic [14:0] echo;
        int          r;
        int          top;

        add_pass(15'd0, 1'b1, 32'd0);
        add_pass(15'd30001, 1'b1, 32'd10);
        add_pass(15'h7FFF, 1'b1, 32'd20);
        add_pass(15'd1, 1'b1, 32'd100);
        add_pass(15'd500, 1'b1, 32'd600);
        add_pass(15'd1166, 1'b1, 32'd900);
        add_pass(15'd1167, 1'b1, 32'd1150);
        add_pass(15'd2000, 1'b1, 32'd1200);
        add_pass(15'd4081, 1'b1, 32'd1250);
        add_pass(15'd4082, 1'b1, 32'd1300);
        add_pass(15'd5000, 1'b1, 32'd1600);
        add_pass(15'd5000, 1'b1, 32'd6299);
        add_pass(15'd5000, 1'b1, 32'd6300);
        add_pass(15'd30000, 1'b1, 32'd6500);
        add_pass(15'd2000, 1'b0, 32'd7000);
        add_pass(15'd5000, 1'b0, 32'd7100);
        add_pass(15'd5000, 1'b1, 32'd7200);
        add_pass(15'd1, 1'b0, 32'd7300);
        add_pass(15'd5000, 1'b1, 32'hFFFF_FFF0);
        add_pass(15'd5000, 1'b0, 32'h0000_0100);
        add_pass(15'd5000, 1'b1, 32'h0000_0200);
        add_pass(15'd0, 1'b0, 32'h0000_1600);
        add_pass(15'd5000, 1'b1, 32'hFFFF_FFFF);
        add_pass(15'd3000, 1'b1, 32'h0000_2000);

        clock_ms = 32'h0000_3000;
        btn_lvl = 1'b1;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                1: write_settings(10'd1000, 7'd100, 7'd100, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: write_settings(10'd0, 7'd0, 7'd0, 16'd0, 16'd0, 16'd0);
                4: write_settings(10'd1023, 7'd127, 7'd127, 16'd100, 16'd1, 16'd1);
                5: write_settings(10'd1, 7'd80, 7'd20, 16'd300, 16'd50, 16'd70);
                7: write_settings(10'd100, 7'd30, 7'd80, 16'd5000, 16'd250, 16'd500);
                default: write_settings(10'($urandom_range(1, 1000)), 7'($urandom_range(0, 100)),
                                        7'($urandom_range(0, 100)),
                                        16'($urandom_range(0, 3000)),
                                        16'($urandom_range(1, 400)),
                                        16'($urandom_range(1, 800)));
            endcase
            top = int'(plan_height) * 59 + 60;
            if (top > 30000)
                top = 30000;
            for (int n = 0; n < PASSES_PER_PHASE; n++) begin
                if (phase == 3 && n == PASSES_PER_PHASE / 2)
                    add_step(STEP_SETTLE, '0, '0);
                r = $urandom_range(0, 99);
                if (r < 80)
                    clock_ms += $urandom_range(0, 700);
                else if (r < 95)
                    clock_ms += $urandom_range(0, 9000);
                else
                    clock_ms = $urandom();
                if ($urandom_range(0, 4) == 0)
                    btn_lvl = !btn_lvl;
                r = $urandom_range(0, 99);
                if (r < 8)
                    echo = '0;
                else if (r < 14)
                    echo = 15'($urandom_range(30001, 32767));
                else if (r < 30)
                    echo = 15'($urandom_range(1, 30000));
                else
                    echo = 15'($urandom_range(1, top));
                add_pass(echo, btn_lvl, clock_ms);
            end
        end

        while (sensor_passes.size() != 0)
            @(posedge i_clk);
        while (push || n_accepted != results_seen)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (panel_expect.size() != 0) begin
            $error("%0d expected results never arrived", panel_expect.size());
            failures++;
        end
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/tlpac_pkg.sv
rtl/core/tlpac_front.sv
rtl/core/tlpac_cls_fifo.sv
rtl/core/tlpac_back.sv
rtl/core/tank_level_pump_alarm_controller_unit.sv
rtl/core/tlpac_checker.sv
test/testbench.sv
